// File: design/stfs_pkg.sv
// Shared constants, types and codes for the container block offset calculator.
package stfs_pkg;

    // Field and datapath widths.
    localparam int IDX_W       = 24;
    localparam int CMD_W       = 2;
    localparam int ADDR_W      = 32;
    localparam int OFS_W       = 40;
    localparam int PHYS_W      = 25;
    localparam int CNT_W       = 18;
    localparam int BLOCK_SHIFT = 12;
    localparam int CFG_IDX_W   = 4;

    // Hash table geometry: each level covers 170 units of the level below.
    localparam int FANOUT  = 170;
    localparam int L1_SPAN = FANOUT * FANOUT;
    localparam int L2_SPAN = L1_SPAN * FANOUT;

    // Reciprocal multipliers for exact division of a 24-bit index.
    localparam int M_W      = 25;
    localparam int PROD_W   = IDX_W + M_W;
    localparam int Q0_SHIFT = 32;
    localparam int Q1_SHIFT = 39;
    localparam int Q0_W     = PROD_W - Q0_SHIFT;
    localparam int Q1_W     = PROD_W - Q1_SHIFT;
    localparam int Q2_W     = 2;
    localparam longint unsigned Q0_MULT_L =
        ((64'd1 << Q0_SHIFT) + 64'(FANOUT) - 64'd1) / 64'(FANOUT);
    localparam longint unsigned Q1_MULT_L =
        ((64'd1 << Q1_SHIFT) + 64'(L1_SPAN) - 64'd1) / 64'(L1_SPAN);
    localparam logic [M_W-1:0] Q0_MULT = M_W'(Q0_MULT_L);
    localparam logic [M_W-1:0] Q1_MULT = M_W'(Q1_MULT_L);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_READ_ONLY  = CFG_IDX_W'(1);

    // Request kinds.
    typedef enum logic [CMD_W-1:0] {
        CMD_DATA  = 2'd0,
        CMD_HASH0 = 2'd1,
        CMD_HASH1 = 2'd2,
        CMD_HASH2 = 2'd3
    } cmd_t;

    // Request after the quotient stages.
    typedef struct packed {
        cmd_t              cmd;
        logic [IDX_W-1:0]  idx;
        logic              per2;
        logic [Q0_W-1:0]   q0;
        logic [Q1_W-1:0]   q1;
        logic [Q2_W-1:0]   q2;
        logic              ge0;
        logic              ge1;
    } quot_t;

endpackage

// File: design/stfs_quot.sv
// Two pipeline stages that divide the block index by the level spans.
module stfs_quot (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  stfs_pkg::cmd_t            in_cmd,
    input  logic [stfs_pkg::IDX_W-1:0] in_idx,
    input  logic                      in_per2,
    output logic                      out_valid,
    input  logic                      out_ready,
    output stfs_pkg::quot_t           out_item
);
    import stfs_pkg::*;

    logic              a_valid_reg;
    cmd_t              a_cmd_reg;
    logic [IDX_W-1:0]  a_idx_reg;
    logic              a_per2_reg;
    logic [PROD_W-1:0] a_p0_reg;
    logic [PROD_W-1:0] a_p1_reg;
    logic [PROD_W-1:0] a_p0_next;
    logic [PROD_W-1:0] a_p1_next;
    logic              a_ready;

    logic              b_valid_reg;
    quot_t             b_item_reg;
    quot_t             b_item_next;
    logic              b_ready;

    // Each stage may load when it is empty or its contents move on.
    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = a_ready;

    // Stage A: reciprocal products.
    assign a_p0_next = PROD_W'(in_idx) * PROD_W'(Q0_MULT);
    assign a_p1_next = PROD_W'(in_idx) * PROD_W'(Q1_MULT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_cmd_reg  <= in_cmd;
            a_idx_reg  <= in_idx;
            a_per2_reg <= in_per2;
            a_p0_reg   <= a_p0_next;
            a_p1_reg   <= a_p1_next;
        end
    end

    // Stage B: quotients from the high product bits, level-2 count by compare.
    always_comb
    begin
        b_item_next.cmd  = a_cmd_reg;
        b_item_next.idx  = a_idx_reg;
        b_item_next.per2 = a_per2_reg;
        b_item_next.q0   = a_p0_reg[Q0_SHIFT +: Q0_W];
        b_item_next.q1   = a_p1_reg[Q1_SHIFT +: Q1_W];
        b_item_next.ge0  = (a_idx_reg >= IDX_W'(FANOUT));
        b_item_next.ge1  = (a_idx_reg >= IDX_W'(L1_SPAN));
        if (a_idx_reg >= IDX_W'(3 * L2_SPAN))
        begin
            b_item_next.q2 = Q2_W'(3);
        end
        else if (a_idx_reg >= IDX_W'(2 * L2_SPAN))
        begin
            b_item_next.q2 = Q2_W'(2);
        end
        else if (a_idx_reg >= IDX_W'(L2_SPAN))
        begin
            b_item_next.q2 = Q2_W'(1);
        end
        else
        begin
            b_item_next.q2 = Q2_W'(0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_item_reg <= b_item_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

    // The level-0 quotient is exact: q0 * 170 <= idx < (q0 + 1) * 170.
    a_q0_exact: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |->
            (34'(b_item_reg.q0) * 34'(FANOUT) <= 34'(b_item_reg.idx)) &&
            (34'(b_item_reg.idx) < (34'(b_item_reg.q0) + 34'd1) * 34'(FANOUT)))
        else $error("level-0 quotient is off");

    // The level-1 quotient is exact as well.
    a_q1_exact: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |->
            (34'(b_item_reg.q1) * 34'(L1_SPAN) <= 34'(b_item_reg.idx)) &&
            (34'(b_item_reg.idx) < (34'(b_item_reg.q1) + 34'd1) * 34'(L1_SPAN)))
        else $error("level-1 quotient is off");

endmodule

// File: design/stfs_phys.sv
// Pipeline stage that forms the physical block number for each request kind.
module stfs_phys (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  stfs_pkg::quot_t             in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [stfs_pkg::PHYS_W-1:0] out_phys
);
    import stfs_pkg::*;

    logic              valid_reg;
    logic [PHYS_W-1:0] phys_reg;
    logic [PHYS_W-1:0] phys_next;
    logic              ready;

    logic [PHYS_W-1:0] per;
    logic [CNT_W-1:0]  cnt;
    logic [PHYS_W-1:0] cnt_blocks;
    logic [PHYS_W-1:0] q0;
    logic [PHYS_W-1:0] q1;
    logic [PHYS_W-1:0] q1_inc;
    logic [PHYS_W-1:0] data_phys;
    logic [PHYS_W-1:0] hash0_phys;
    logic [PHYS_W-1:0] hash1_phys;
    logic [PHYS_W-1:0] hash2_phys;

    assign ready    = !valid_reg || out_ready;
    assign in_ready = ready;

    // Blocks per table, and the quotients at full width.
    assign per    = in_item.per2 ? PHYS_W'(2) : PHYS_W'(1);
    assign q0     = PHYS_W'(in_item.q0);
    assign q1     = PHYS_W'(in_item.q1);
    assign q1_inc = q1 + PHYS_W'(1);

    // Data block: skip every table stored up to this block at each level.
    always_comb
    begin
        cnt = CNT_W'(in_item.q0) + CNT_W'(1);
        if (in_item.ge0)
        begin
            cnt = cnt + CNT_W'(in_item.q1) + CNT_W'(1);
        end
        if (in_item.ge1)
        begin
            cnt = cnt + CNT_W'(in_item.q2) + CNT_W'(1);
        end
    end

    assign cnt_blocks = in_item.per2 ? (PHYS_W'(cnt) << 1) : PHYS_W'(cnt);
    assign data_phys  = PHYS_W'(in_item.idx) + cnt_blocks;

    // Level-0 table: the first block for the first run, otherwise after the
    // earlier data runs and the tables above them.
    always_comb
    begin
        if (!in_item.ge0)
        begin
            hash0_phys = '0;
        end
        else
        begin
            hash0_phys = q0 * PHYS_W'(FANOUT) + (in_item.per2 ? (q0 << 1) : q0)
                       + (in_item.per2 ? (q1_inc << 1) : q1_inc);
            if (in_item.ge1)
            begin
                hash0_phys = hash0_phys + per;
            end
        end
    end

    // Level-1 table: just after the first level-0 run for small blocks.
    always_comb
    begin
        if (!in_item.ge1)
        begin
            hash1_phys = PHYS_W'(FANOUT) + per;
        end
        else
        begin
            hash1_phys = q1 * PHYS_W'(L1_SPAN) + q1 * PHYS_W'(FANOUT + 1) * per + per;
        end
    end

    // Level-2 table: one for the whole container.
    assign hash2_phys = PHYS_W'(L1_SPAN) + PHYS_W'(FANOUT + 1) * per;

    always_comb
    begin
        case (in_item.cmd)
            CMD_DATA:  phys_next = data_phys;
            CMD_HASH0: phys_next = hash0_phys;
            CMD_HASH1: phys_next = hash1_phys;
            CMD_HASH2: phys_next = hash2_phys;
            default:   phys_next = data_phys;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            phys_reg <= phys_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_phys  = phys_reg;

endmodule

// File: design/stfs_add.sv
// Output stage that scales the block number and adds the data start.
module stfs_add (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [stfs_pkg::PHYS_W-1:0] in_phys,
    input  logic [stfs_pkg::ADDR_W-1:0] data_start,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [stfs_pkg::OFS_W-1:0]  out_offset
);
    import stfs_pkg::*;

    logic             valid_reg;
    logic [OFS_W-1:0] offset_reg;
    logic [OFS_W-1:0] offset_next;
    logic             ready;

    assign ready    = !valid_reg || out_ready;
    assign in_ready = ready;

    // Byte offset wraps at 40 bits.
    assign offset_next = OFS_W'(data_start) + (OFS_W'(in_phys) << BLOCK_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            offset_reg <= offset_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_offset = offset_reg;

endmodule

// File: design/stfs_block_offset_calc.sv
// Top level of the container block offset calculator.
//
// Usage: each transaction on the s_ group carries a request kind in s_tuser
// (data block, or the level-0, level-1 or level-2 hash table) and a 24-bit
// logical block number in s_tdata. One transaction on the m_ group returns the
// 40-bit byte offset of that block in the container file, in request order.
// The cfg_ channel writes data_start (index 0) and read_only (index 1); it is
// always ready, and other indexes are ignored. Write it only while no request
// is in flight.
// There are four register stages: two for the reciprocal multiplies and
// quotients, one for the block number and one for the final 40-bit add; the
// first is loaded at the accepting edge. One request is accepted every cycle
// while the output drains, set by the four-stage pipeline with one register
// per stage. When m_tready is low, stages fill up behind the output register
// and s_tready drops once the pipeline is full; nothing is lost or repeated.
// Reset clears all stage valid bits and sets data_start to 0, read_only to 1.
module stfs_block_offset_calc (
    input  logic                           clk,
    input  logic                           rst_n,
    // Request channel.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // [23:0] block number
    input  logic [1:0]                     s_tuser,   // [1:0] cmd
    // Result channel.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [39:0]                    m_tdata,   // [39:0] byte_offset
    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [stfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [stfs_pkg::ADDR_W-1:0]    cfg_data
);
    import stfs_pkg::*;

    logic [ADDR_W-1:0] data_start_reg;
    logic              read_only_reg;

    logic              quot_valid;
    logic              quot_ready;
    quot_t             quot_item;
    logic              phys_valid;
    logic              phys_ready;
    logic [PHYS_W-1:0] phys;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_start_reg <= '0;
            read_only_reg  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_DATA_START)
            begin
                data_start_reg <= cfg_data;
            end
            else if (cfg_index == CFG_READ_ONLY)
            begin
                read_only_reg <= cfg_data[0];
            end
        end
    end

    // Quotient stages.
    stfs_quot u_quot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (cmd_t'(s_tuser)),
        .in_idx    (s_tdata),
        .in_per2   (!read_only_reg),
        .out_valid (quot_valid),
        .out_ready (quot_ready),
        .out_item  (quot_item)
    );

    // Block number stage.
    stfs_phys u_phys (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (quot_valid),
        .in_ready  (quot_ready),
        .in_item   (quot_item),
        .out_valid (phys_valid),
        .out_ready (phys_ready),
        .out_phys  (phys)
    );

    // Output stage.
    stfs_add u_add (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (phys_valid),
        .in_ready   (phys_ready),
        .in_phys    (phys),
        .data_start (data_start_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_offset (m_tdata)
    );

    // A ready receiver lets every stage move, so requests are never held off.
    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("request stalled while the receiver is ready");

endmodule

// File: tb/sv/stfs_block_offset_calc_tb.sv
// Self-checking testbench for the container block offset calculator.
`timescale 1ns / 100ps

module stfs_block_offset_calc_tb;

    import stfs_pkg::*;

    localparam int PIPE_LAT    = 4;
    localparam int HASH_LEVELS = 3;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 230;
    localparam int MAX_REPORTS = 40;
    localparam int DIR_ROWS    = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_READ_ONLY + 1'b1;

    localparam longint unsigned FAN   = FANOUT;
    localparam longint unsigned SPAN1 = L1_SPAN;

    // One row of the directed sequence; ofs is used only when known is set.
    typedef struct packed {
        cmd_t              cmd;
        logic [IDX_W-1:0]  idx;
        logic              known;
        logic [OFS_W-1:0]  ofs;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata = '0;   // [23:0] block number
    logic [1:0]           s_tuser = '0;   // [1:0] cmd
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [39:0]          m_tdata;        // [39:0] byte_offset
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data = '0;

    // Register copies used by the offset predictor.
    logic [ADDR_W-1:0]    cur_start = '0;
    logic                 cur_ro = 1'b1;

    logic [OFS_W-1:0]     expected_offsets[$];
    logic [OFS_W-1:0]     want_ofs;
    int                   error_count = 0;
    bit                   quiet = 1'b0;
    bit                   hold_req = 1'b0;

    // Directed requests; typed offsets hold for the reset register values.
    dir_row_t directed_rows [0:DIR_ROWS-1] = '{
        '{CMD_DATA,  24'd0,        1'b1, 40'h00_0000_1000},
        '{CMD_HASH0, 24'd0,        1'b1, 40'h00_0000_0000},
        '{CMD_HASH1, 24'd0,        1'b1, 40'h00_000A_B000},
        '{CMD_HASH2, 24'd0,        1'b1, 40'h00_0718_F000},
        '{CMD_HASH2, 24'hFF_FFFF,  1'b1, 40'h00_0718_F000},
        '{CMD_DATA,  24'd169,      1'b1, 40'h00_000A_A000},
        '{CMD_HASH0, 24'd169,      1'b1, 40'h00_0000_0000},
        '{CMD_HASH1, 24'd28899,    1'b1, 40'h00_000A_B000},
        '{CMD_DATA,  24'd170,      1'b0, 40'h0},
        '{CMD_HASH0, 24'd170,      1'b0, 40'h0},
        '{CMD_DATA,  24'd28899,    1'b0, 40'h0},
        '{CMD_DATA,  24'd28900,    1'b0, 40'h0},
        '{CMD_HASH1, 24'd28900,    1'b0, 40'h0},
        '{CMD_HASH0, 24'd28900,    1'b0, 40'h0},
        '{CMD_DATA,  24'd4912999,  1'b0, 40'h0},
        '{CMD_DATA,  24'd4913000,  1'b0, 40'h0},
        '{CMD_DATA,  24'hFF_FFFF,  1'b0, 40'h0},
        '{CMD_HASH0, 24'hFF_FFFF,  1'b0, 40'h0},
        '{CMD_HASH1, 24'hFF_FFFF,  1'b0, 40'h0},
        '{CMD_DATA,  24'h55_5555,  1'b0, 40'h0}
    };

    stfs_block_offset_calc DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Byte offset of a request under the current register values.
    function automatic logic [OFS_W-1:0] calc_offset(input cmd_t kind,
                                                     input logic [IDX_W-1:0] idx);
        longint unsigned n;
        longint unsigned per;
        longint unsigned span;
        longint unsigned phys;
        longint unsigned step0;
        longint unsigned step1;
        n = idx;
        per = cur_ro ? 64'd1 : 64'd2;
        step0 = FAN + per;
        step1 = SPAN1 + (FAN + 64'd1) * per;
        case (kind)
            CMD_DATA:
            begin
                // Skip every table stored in front of the block, level by level.
                phys = n;
                span = FAN;
                for (int lvl = 0; lvl < HASH_LEVELS; lvl++)
                begin
                    phys += ((n + span) / span) * per;
                    if (n < span)
                        break;
                    span *= FAN;
                end
            end
            CMD_HASH0:
            begin
                if (n < FAN)
                    phys = 0;
                else
                begin
                    phys = (n / FAN) * step0 + (n / SPAN1 + 64'd1) * per;
                    if (n >= SPAN1)
                        phys += per;
                end
            end
            CMD_HASH1:
                phys = (n < SPAN1) ? step0 : (n / SPAN1) * step1 + per;
            default:
                phys = step1;
        endcase
        return OFS_W'(longint'(cur_start) + (phys << BLOCK_SHIFT));
    endfunction

    // Block number biased toward the table boundaries.
    function automatic logic [IDX_W-1:0] pick_index();
        int base;
        case ($urandom_range(0, 9))
            0, 1, 2: base = int'($urandom & 32'hFF_FFFF);
            3:       base = $urandom_range(0, 400);
            4:       base = FANOUT * $urandom_range(1, 98689);
            5:       base = L1_SPAN * $urandom_range(1, 580);
            6:       base = L2_SPAN * $urandom_range(1, 3);
            7:       base = 24'hFF_FFFF - $urandom_range(0, 8);
            default: base = $urandom_range(0, 100000);
        endcase
        return IDX_W'(base + $urandom_range(0, 4) - 2);
    endfunction

    task automatic report_mismatch(input string what, input logic [OFS_W-1:0] got,
                                   input logic [OFS_W-1:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Offers one request and records its offset once the transaction completes.
    task automatic send_req(input cmd_t kind, input logic [IDX_W-1:0] idx,
                            input logic known, input logic [OFS_W-1:0] ofs);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= idx;
        do @(posedge clk); while (s_tready !== 1'b1);
        expected_offsets.insert(expected_offsets.size(),
                                known ? ofs : calc_offset(kind, idx));
    endtask

    // Stops offering and waits until every pending result has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_offsets.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    // Register write; the caller lowers cfg_valid after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [ADDR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (ri)
            CFG_DATA_START: cur_start = val;
            CFG_READ_ONLY:  cur_ro = val[0];
            default:        ;
        endcase
    endtask

    task automatic run_directed(input logic use_known);
        foreach (directed_rows[i])
            send_req(directed_rows[i].cmd, directed_rows[i].idx,
                     use_known & directed_rows[i].known, directed_rows[i].ofs);
    endtask

    // Result side: random stalls, plus one long hold-off when requested.
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else if (quiet)
                stall = 0;
            else
                stall = $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
        end
    end

    // Compare each result transaction with the oldest pending offset.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (expected_offsets.size() == 0)
                report_mismatch("result with nothing pending", m_tdata, '0);
            else
            begin
                want_ofs = expected_offsets.pop_front();
                if (m_tdata !== want_ofs)
                    report_mismatch("byte_offset", m_tdata, want_ofs);
            end
        end
    end

    // Main sequence: reset, directed requests, then random phases.
    initial
    begin : stimulus
        logic [ADDR_W-1:0] start_val;
        logic              ro_val;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values first, with typed offsets where they are obvious.
        run_directed(1'b1);
        drain_results();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    start_val = 32'hFFFF_FFFF;
                    ro_val = 1'b0;
                end
                1:
                begin
                    start_val = 32'hFFFF_F000;
                    ro_val = 1'b1;
                end
                2:
                begin
                    start_val = 32'h0;
                    ro_val = 1'b0;
                end
                3:
                begin
                    start_val = $urandom & 32'hFFFF_F000;
                    ro_val = 1'b1;
                end
                4:
                begin
                    start_val = $urandom & 32'hFFFF_F000;
                    ro_val = 1'b0;
                end
                default:
                begin
                    // Unaligned data start is added as is.
                    start_val = $urandom;
                    ro_val = 1'($urandom_range(0, 1));
                end
            endcase
            write_reg(CFG_DATA_START, start_val);
            write_reg(CFG_READ_ONLY, {31'($urandom_range(0, 32'h7FFF_FFFF)), ro_val});
            // Writes beyond the register list must leave both registers alone.
            write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, 15)), $urandom);
            cfg_valid <= 1'b0;

            if (ph == 0)
                run_directed(1'b0);

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 40 == 0)
                    quiet = ($urandom_range(0, 4) == 0);
                // Long receiver hold-off while requests keep coming back to back.
                if (ph == 2 && i == 50)
                begin
                    hold_req = 1'b1;
                    quiet = 1'b1;
                end
                // Sender pause until every pending result has come out.
                if (ph == 3 && i == 100)
                    drain_results();
                send_req(cmd_t'($urandom_range(0, 3)), pick_index(), 1'b0, '0);
            end
            quiet = 1'b0;
            drain_results();
        end

        if (error_count == 0 && expected_offsets.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
design/stfs_pkg.sv
design/stfs_quot.sv
design/stfs_phys.sv
design/stfs_add.sv
design/stfs_block_offset_calc.sv
tb/sv/stfs_block_offset_calc_tb.sv
